// ===== hdl/bmpdec_pkg.sv =====
// Shared types, codes and result builders for the BMP stream decoder.
// Used by bmpdec_parser, bmpdec_out_queue and bmp_stream_to_rgba_decoder_top.
package bmpdec_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_SHORT  = 3'd1;
  localparam logic [2:0] ERR_SIG    = 3'd2;
  localparam logic [2:0] ERR_DEPTH  = 3'd3;
  localparam logic [2:0] ERR_DIMS   = 3'd4;
  localparam logic [2:0] ERR_OFFSET = 3'd5;
  localparam logic [2:0] ERR_TRUNC  = 3'd6;

  // Header byte positions.
  localparam logic [5:0] HDR_SIG0   = 6'd0;
  localparam logic [5:0] HDR_SIG1   = 6'd1;
  localparam logic [5:0] HDR_OFF_LO = 6'd10;
  localparam logic [5:0] HDR_OFF_HI = 6'd13;
  localparam logic [5:0] HDR_WID_LO = 6'd18;
  localparam logic [5:0] HDR_WID_HI = 6'd21;
  localparam logic [5:0] HDR_HGT_LO = 6'd22;
  localparam logic [5:0] HDR_HGT_HI = 6'd25;
  localparam logic [5:0] HDR_DEPTH  = 6'd28;
  localparam logic [5:0] HDR_LAST   = 6'd53;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [7:0]  DEPTH_24     = 8'd24;
  localparam logic [7:0]  DEPTH_32     = 8'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0] OFFSET_MIN   = 32'd54;

  localparam int IDX_W   = 24;
  localparam int DIM_W   = 13;
  localparam int TDATA_W = 88;

  // Output queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [2:0]       error_code;
    logic             last;
  } result_t;

  typedef struct packed {
    logic              space_ok;
    logic [QCNT_W-1:0] level;
  } q_status_t;

  function automatic result_t make_error(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t make_header(input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h);
    result_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.image_width = w;
    r.image_height = h;
    return r;
  endfunction

  function automatic result_t make_pixel(input logic [IDX_W-1:0] idx,
                                         input logic [7:0] r_in,
                                         input logic [7:0] g_in,
                                         input logic [7:0] b_in,
                                         input logic [7:0] a_in,
                                         input logic fin);
    result_t r;
    r = '0;
    r.kind = KIND_PIXEL;
    r.pixel_index = idx;
    r.red = r_in;
    r.green = g_in;
    r.blue = b_in;
    r.alpha = a_in;
    r.last = fin;
    return r;
  endfunction

endpackage

// ===== hdl/bmpdec_parser.sv =====
// Input register and per-byte decode logic of the BMP stream decoder.
// Produces up to two results per byte. Depends on bmpdec_pkg.
module bmpdec_parser import bmpdec_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  input  q_status_t  q_stat,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_count
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;
  localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
  localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

  // Input register.
  logic       in_full;
  logic [7:0] d;
  logic       eof;
  logic       fire;

  assign in_ready = !in_full || q_stat.space_ok;
  assign fire = in_full && q_stat.space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d <= in_byte;
      eof <= in_eof;
    end
  end

  // Decode state.
  phase_t          phase, phase_next;
  logic [31:0]     byte_position, byte_position_next;
  logic            sig_ok, sig_ok_next;
  logic [31:0]     pixel_offset, pixel_offset_next;
  logic [31:0]     width_value, width_value_next;
  logic [31:0]     height_value, height_value_next;
  logic [7:0]      depth_byte, depth_byte_next;
  logic [23:0]     pixel_bytes, pixel_bytes_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [WW-1:0]   column, column_next;
  logic [HW-1:0]   row, row_next;
  logic [1:0]      pad_left, pad_left_next;
  logic [IDX_W-1:0] row_base, row_base_next;

  // Values derived from the header, refreshed every cycle. They settle long
  // before the last header byte arrives.
  logic [31:0]      habs;
  logic [HW-1:0]    h_m1;
  logic [WW-1:0]    w_m1;
  logic [IDX_W-1:0] base_prod;
  logic [PW-1:0]    prod_full;

  assign prod_full = PW'(h_m1) * PW'(width_value[WW-1:0]);

  always_ff @(posedge clk) begin
    habs <= height_value[31] ? (32'd0 - height_value) : height_value;
    h_m1 <= habs[HW-1:0] - HW'(1);
    w_m1 <= width_value[WW-1:0] - WW'(1);
    base_prod <= IDX_W'(prod_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
    end else begin
      phase <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    sig_ok <= sig_ok_next;
    pixel_offset <= pixel_offset_next;
    width_value <= width_value_next;
    height_value <= height_value_next;
    depth_byte <= depth_byte_next;
    pixel_bytes <= pixel_bytes_next;
    byte_in_pixel <= byte_in_pixel_next;
    column <= column_next;
    row <= row_next;
    pad_left <= pad_left_next;
    row_base <= row_base_next;
  end

  logic [5:0]       hdr_pos;
  logic [1:0]       hdr_lane;
  logic [2:0]       hdr_err;
  logic             bpp4;
  logic [1:0]       bip_last;
  logic [7:0]       red_val;
  logic [7:0]       alpha_val;
  logic             is_final;
  logic [IDX_W-1:0] wid24;
  logic [IDX_W-1:0] pix_idx;

  assign hdr_pos = byte_position[5:0];
  assign bpp4 = (depth_byte == DEPTH_32);
  assign bip_last = bpp4 ? 2'd3 : 2'd2;
  assign red_val = bpp4 ? pixel_bytes[23:16] : d;
  assign alpha_val = bpp4 ? d : ALPHA_OPAQUE;
  assign is_final = (row == h_m1) && (column == w_m1);
  assign wid24 = IDX_W'(width_value[WW-1:0]);
  assign pix_idx = row_base + IDX_W'(column);

  // Checked in this order: signature, depth, dimensions, offset.
  always_comb begin
    if (!sig_ok) begin
      hdr_err = ERR_SIG;
    end else if (depth_byte != DEPTH_24 && depth_byte != DEPTH_32) begin
      hdr_err = ERR_DEPTH;
    end else if (width_value == '0 || width_value[31] || habs == '0 ||
                 width_value > MAX_W32 || habs > MAX_H32) begin
      hdr_err = ERR_DIMS;
    end else if (pixel_offset < OFFSET_MIN) begin
      hdr_err = ERR_OFFSET;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  logic restart;
  logic pix_final;

  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    sig_ok_next = sig_ok;
    pixel_offset_next = pixel_offset;
    width_value_next = width_value;
    height_value_next = height_value;
    depth_byte_next = depth_byte;
    pixel_bytes_next = pixel_bytes;
    byte_in_pixel_next = byte_in_pixel;
    column_next = column;
    row_next = row;
    pad_left_next = pad_left;
    row_base_next = row_base;
    res0 = '0;
    res1 = '0;
    res_count = 2'd0;
    restart = 1'b0;
    pix_final = 1'b0;
    hdr_lane = 2'd0;

    if (fire) begin
      unique case (phase)
        PH_HEADER: begin
          // Every captured lane is written before the header is checked, so
          // the capture registers never need clearing between files.
          unique case (hdr_pos) inside
            HDR_SIG0: sig_ok_next = (d == SIG_B);
            HDR_SIG1: sig_ok_next = sig_ok & (d == SIG_M);
            [HDR_OFF_LO:HDR_OFF_HI]: begin
              hdr_lane = 2'(hdr_pos - HDR_OFF_LO);
              pixel_offset_next[{hdr_lane, 3'b000} +: 8] = d;
            end
            [HDR_WID_LO:HDR_WID_HI]: begin
              hdr_lane = 2'(hdr_pos - HDR_WID_LO);
              width_value_next[{hdr_lane, 3'b000} +: 8] = d;
            end
            [HDR_HGT_LO:HDR_HGT_HI]: begin
              hdr_lane = 2'(hdr_pos - HDR_HGT_LO);
              height_value_next[{hdr_lane, 3'b000} +: 8] = d;
            end
            HDR_DEPTH: depth_byte_next = d;
            default: ;
          endcase
          byte_position_next = byte_position + 32'd1;
          if (hdr_pos != HDR_LAST) begin
            if (eof) begin
              res0 = make_error(ERR_SHORT);
              res_count = 2'd1;
              restart = 1'b1;
            end
          end else if (hdr_err != ERR_NONE) begin
            res0 = make_error(hdr_err);
            res_count = 2'd1;
            if (eof) begin
              restart = 1'b1;
            end else begin
              phase_next = PH_DONE;
            end
          end else begin
            res0 = make_header(width_value[DIM_W-1:0], habs[DIM_W-1:0]);
            res_count = 2'd1;
            row_next = '0;
            column_next = '0;
            byte_in_pixel_next = 2'd0;
            pad_left_next = 2'd0;
            row_base_next = height_value[31] ? '0 : base_prod;
            phase_next = (pixel_offset == OFFSET_MIN) ? PH_PIXELS : PH_SKIP;
            if (eof) begin
              res1 = make_error(ERR_TRUNC);
              res_count = 2'd2;
              restart = 1'b1;
            end
          end
        end

        PH_SKIP: begin
          if (byte_position == pixel_offset - 32'd1) begin
            phase_next = PH_PIXELS;
          end
          byte_position_next = byte_position + 32'd1;
          if (eof) begin
            res0 = make_error(ERR_TRUNC);
            res_count = 2'd1;
            restart = 1'b1;
          end
        end

        PH_PIXELS: begin
          if (pad_left != 2'd0) begin
            pad_left_next = pad_left - 2'd1;
          end else if (byte_in_pixel != bip_last) begin
            case (byte_in_pixel)
              2'd0:    pixel_bytes_next[7:0] = d;
              2'd1:    pixel_bytes_next[15:8] = d;
              default: pixel_bytes_next[23:16] = d;
            endcase
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end else begin
            res0 = make_pixel(pix_idx, red_val, pixel_bytes[15:8],
                              pixel_bytes[7:0], alpha_val, is_final);
            res_count = 2'd1;
            byte_in_pixel_next = 2'd0;
            if (is_final) begin
              pix_final = 1'b1;
              if (eof) begin
                restart = 1'b1;
              end else begin
                phase_next = PH_DONE;
              end
            end else if (column == w_m1) begin
              // Row wrap: bottom-up files walk the row base downward.
              column_next = '0;
              row_next = row + HW'(1);
              pad_left_next = bpp4 ? 2'd0 : width_value[1:0];
              row_base_next = height_value[31] ? (row_base + wid24)
                                               : (row_base - wid24);
            end else begin
              column_next = column + WW'(1);
            end
          end
          if (eof && !pix_final) begin
            if (res_count == 2'd0) begin
              res0 = make_error(ERR_TRUNC);
              res_count = 2'd1;
            end else begin
              res1 = make_error(ERR_TRUNC);
              res_count = 2'd2;
            end
            restart = 1'b1;
          end
        end

        default: begin
          if (eof) begin
            restart = 1'b1;
          end
        end
      endcase

      if (restart) begin
        phase_next = PH_HEADER;
        byte_position_next = '0;
      end
    end
  end

endmodule

// ===== hdl/bmpdec_out_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and
// delivers one per beat. Depends on bmpdec_pkg.
module bmpdec_out_queue import bmpdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output q_status_t  stat,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_item
);

  result_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] level;
  logic              pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_item = slots[rd_ptr];
  // Room for a full pair of results is required before a byte is decoded.
  assign stat.space_ok = (level <= QCNT_W'(QDEPTH - 2));
  assign stat.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      level <= level + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push1;
    end
  end

endmodule

// ===== hdl/bmp_stream_to_rgba_decoder_top.sv =====
// Top level of the BMP stream decoder: byte stream in, RGBA pixel results out.
// Instantiates bmpdec_parser and bmpdec_out_queue; depends on bmpdec_pkg.
//
// Usage: a BMP file enters on the slave stream one byte per beat, with s_tlast
// marking the final byte of the file. The block parses the 54-byte header,
// emits one header result (image size) or one error result, skips to the pixel
// offset and then emits one pixel result per stored pixel, with its top-down
// index, RGBA components and m_tlast set on the final pixel. Error results
// also carry m_tlast. The result kind travels on m_tuser.
// An accepted byte is held in the input register until the result queue has
// room for a pair of results; it is then decoded, and its results are written
// into the result queue, from which the master side presents them in order.
// Throughput: one byte per cycle while the queue has room for a pair. A single
// byte yields at most two results (a header or a non-final pixel, then a
// truncation error); the four-entry result queue absorbs that, and a byte is
// decoded only when two queue slots are free, so s_tready depends only on
// registered state.
// Reset clears the input register, the queue and the parser phase; the next
// byte starts a new header. A new file also starts after any s_tlast byte.
// When the receiver stalls, results wait in the queue; s_tready drops once the
// input register waits for queue room; no result is dropped or repeated.
module bmp_stream_to_rgba_decoder_top import bmpdec_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // [7:0] data_byte
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // [23:0] pixel_index, [31:24] red, [39:32] green, [47:40] blue,
  // [55:48] alpha, [68:56] image_width, [81:69] image_height,
  // [84:82] error_code, [87:85] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser,  // [1:0] kind
  output logic               m_tlast
);

  q_status_t  q_stat;
  result_t    res0;
  result_t    res1;
  logic [1:0] res_count;
  result_t    head;

  bmpdec_parser #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_eof   (s_tlast),
    .q_stat   (q_stat),
    .res0     (res0),
    .res1     (res1),
    .res_count(res_count)
  );

  bmpdec_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_count(res_count),
    .push0     (res0),
    .push1     (res1),
    .stat      (q_stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (head)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_tdata = {3'b000, head.error_code, head.image_height, head.image_width,
                    head.alpha, head.blue, head.green, head.red,
                    head.pixel_index};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  // The queue never holds more results than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // The parser only produces results when a full pair of slots is free.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_count != 2'd0 |-> q_stat.space_ok)
    else $error("results produced without queue room");

  // A second result from one byte is always a terminating error.
  a_second_is_error: assert property (@(posedge clk) disable iff (rst)
    res_count == 2'd2 |-> (res1.kind == KIND_ERROR) && res1.last)
    else $error("second result of a byte is not an error");

  // Every delivered error result closes the file.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ERROR) |-> m_tlast)
    else $error("error result without last");

endmodule

// ===== tb/bmp_stream_to_rgba_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bmp_stream_to_rgba_decoder_top: BMP files go in byte by byte,
// and every header, pixel and error result is checked against a behavioral decoder.
// Depends on bmpdec_pkg for result types, kinds, error codes and header positions.
module bmp_stream_to_rgba_decoder_top_tb;
  import bmpdec_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  // Bytes of random files to send after the directed files.
  localparam int RANDOM_BYTES = 540;
  // A byte that is neither signature character.
  localparam logic [7:0] NOT_SIG = 8'h58;

  // Behavioral decoder plus the store of results it has predicted but not yet seen.
  class rgba_scoreboard;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned checked;

    // Decoder state of the file in flight; restart clears it.
    phase_t    ph;
    bit [31:0] pos, pix_off, wid, hgt;
    bit [31:0] col, row, bip, pad;
    bit [7:0]  depth;
    bit        sig_ok;
    bit [23:0] acc, row_base;

    function new();
      restart();
    endfunction

    function void restart();
      ph = PH_HEADER;
      pos = 0; pix_off = 0; wid = 0; hgt = 0;
      col = 0; row = 0; bip = 0; pad = 0;
      depth = 0; sig_ok = 0; acc = 0; row_base = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit [31:0] abs_height();
      return hgt[31] ? (32'd0 - hgt) : hgt;
    endfunction

    // Start index of the current stored row in top-down order.
    function void place_row();
      bit [31:0] y;
      y = hgt[31] ? row : (abs_height() - 32'd1 - row);
      row_base = 24'(y * wid);
    endfunction

    function void push_result(bit [1:0] kind, bit [IDX_W-1:0] idx, bit [7:0] r, bit [7:0] g,
                              bit [7:0] b, bit [7:0] a, bit [DIM_W-1:0] w,
                              bit [DIM_W-1:0] h, bit [2:0] err, bit fin);
      result_t res;
      res.kind = kind;
      res.pixel_index = idx;
      res.red = r;
      res.green = g;
      res.blue = b;
      res.alpha = a;
      res.image_width = w;
      res.image_height = h;
      res.error_code = err;
      res.last = fin;
      pending_results.push_back(res);
    endfunction

    function void push_error(bit [2:0] err);
      push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, err, 1'b1);
    endfunction

    // Checks are ordered: signature, depth, dimensions, then offset.
    function logic [2:0] header_verdict();
      bit [31:0] h;
      h = abs_height();
      if (!sig_ok) return ERR_SIG;
      if (depth != DEPTH_24 && depth != DEPTH_32) return ERR_DEPTH;
      if (wid == 0 || wid[31] || h == 0 || wid > MAX_W || h > MAX_H) return ERR_DIMS;
      if (pix_off < OFFSET_MIN) return ERR_OFFSET;
      return ERR_NONE;
    endfunction

    // Advances the decoder by one accepted byte and queues what it produces.
    function void decode_byte(bit [7:0] d, bit eof);
      bit [31:0]  p, h, bpp;
      bit [7:0]   r, g, b, a;
      bit         fin;
      logic [2:0] verdict;
      case (ph)
        PH_HEADER: begin
          p = pos;
          if (p == HDR_SIG0) sig_ok = (d == SIG_B);
          else if (p == HDR_SIG1) sig_ok = sig_ok && (d == SIG_M);
          else if (p >= HDR_OFF_LO && p <= HDR_OFF_HI)
            pix_off |= 32'(d) << (8 * (p - HDR_OFF_LO));
          else if (p >= HDR_WID_LO && p <= HDR_WID_HI)
            wid |= 32'(d) << (8 * (p - HDR_WID_LO));
          else if (p >= HDR_HGT_LO && p <= HDR_HGT_HI)
            hgt |= 32'(d) << (8 * (p - HDR_HGT_LO));
          else if (p == HDR_DEPTH) depth = d;
          pos = p + 1;
          if (p < HDR_LAST) begin
            if (eof) begin
              push_error(ERR_SHORT);
              restart();
            end
            return;
          end
          verdict = header_verdict();
          if (verdict != ERR_NONE) begin
            push_error(verdict);
            if (eof) restart();
            else ph = PH_DONE;
            return;
          end
          push_result(KIND_HEADER, '0, '0, '0, '0, '0, wid[DIM_W-1:0],
                      DIM_W'(abs_height()), ERR_NONE, 1'b0);
          row = 0; col = 0; bip = 0; pad = 0;
          place_row();
          ph = (pix_off == OFFSET_MIN) ? PH_PIXELS : PH_SKIP;
          if (eof) begin
            push_error(ERR_TRUNC);
            restart();
          end
        end
        PH_SKIP: begin
          if (pos == pix_off - 1) ph = PH_PIXELS;
          pos++;
          if (eof) begin
            push_error(ERR_TRUNC);
            restart();
          end
        end
        PH_PIXELS: begin
          bpp = (depth == DEPTH_32) ? 4 : 3;
          h = abs_height();
          if (pad != 0) begin
            pad--;
          end else if (bip + 1 < bpp && bip < 3) begin
            acc = acc | (24'(d) << (8 * bip));
            bip++;
          end else begin
            if (bpp == 3) begin
              acc = acc | {d, 16'h0000};
              a = ALPHA_OPAQUE;
            end else begin
              a = d;
            end
            b = acc[7:0];
            g = acc[15:8];
            r = acc[23:16];
            fin = (row == h - 1) && (col == wid - 1);
            push_result(KIND_PIXEL, 24'(row_base + col), r, g, b, a, '0, '0, ERR_NONE, fin);
            acc = 0;
            bip = 0;
            if (fin) begin
              if (eof) restart();
              else ph = PH_DONE;
              return;
            end
            col++;
            if (col >= wid) begin
              col = 0;
              row++;
              pad = (4 - ((wid * bpp) & 3)) & 3;
              place_row();
            end
          end
          if (eof) begin
            push_error(ERR_TRUNC);
            restart();
          end
        end
        default: begin
          if (eof) restart();
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: mismatch on result %0d: %s", $time, checked, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result of kind %0d arrived with none pending", got.kind));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.pixel_index !== want.pixel_index)
        report($sformatf("pixel_index %0d, expected %0d", got.pixel_index, want.pixel_index));
      if (got.red !== want.red)
        report($sformatf("red %0d, expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green %0d, expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue %0d, expected %0d", got.blue, want.blue));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha %0d, expected %0d", got.alpha, want.alpha));
      if (got.image_width !== want.image_width)
        report($sformatf("image_width %0d, expected %0d", got.image_width, want.image_width));
      if (got.image_height !== want.image_height)
        report($sformatf("image_height %0d, expected %0d", got.image_height,
                         want.image_height));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, expected %0d", got.error_code, want.error_code));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  rgba_scoreboard sb = new();

  // The file being sent, and the row padding of its last row.
  bit [7:0]    bmp_q[$];
  int unsigned tail_pad;
  int unsigned bytes_sent;
  // Sender burst bookkeeping and the receiver's stall pattern.
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  bmp_stream_to_rgba_decoder_top #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Builds a file in bmp_q: a 54-byte header with random filler in the unused bytes,
  // and, when asked, the gap up to the pixel offset plus every row with its padding.
  task automatic make_bmp(input bit [7:0] s0, input bit [7:0] s1, input bit [31:0] off,
                          input bit [31:0] w, input bit [31:0] h, input bit [7:0] dep,
                          input bit pixels);
    bit [31:0] rows, row_len;
    bmp_q.delete();
    repeat (HDR_LAST + 1) bmp_q.push_back(8'($urandom));
    bmp_q[HDR_SIG0] = s0;
    bmp_q[HDR_SIG1] = s1;
    bmp_q[HDR_DEPTH] = dep;
    for (int i = 0; i < 4; i++) begin
      bmp_q[HDR_OFF_LO + i] = off[8*i +: 8];
      bmp_q[HDR_WID_LO + i] = w[8*i +: 8];
      bmp_q[HDR_HGT_LO + i] = h[8*i +: 8];
    end
    tail_pad = 0;
    if (pixels) begin
      rows = h[31] ? (32'd0 - h) : h;
      row_len = w * ((dep == DEPTH_32) ? 4 : 3);
      tail_pad = (4 - (row_len & 3)) & 3;
      repeat (off - OFFSET_MIN + rows * (row_len + tail_pad))
        bmp_q.push_back(8'($urandom));
    end
  endtask

  // One beat on the slave side. The sender runs in bursts; between bursts it may
  // drop tvalid for a random gap. The beat is credited to the decoder at the edge
  // where tvalid and tready are both high.
  task automatic send_byte(input logic [7:0] d, input logic eof);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.decode_byte(d, eof);
  endtask

  // Sends the first n bytes of the file with tlast on the last of them. Past the
  // end of bmp_q the bytes are random, which makes trailing data or pixel data.
  task automatic send_bmp(input int n);
    for (int i = 0; i < n; i++)
      send_byte((i < bmp_q.size()) ? bmp_q[i] : 8'($urandom), i == n - 1);
    bytes_sent += n;
  endtask

  // Receiver: checks each accepted result beat, then picks the next tready value.
  // The pattern switches every so often between always ready, random stalls, a
  // steady one-in-three rate and long stalls that fill the result queue.
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.pixel_index = m_tdata[23:0];
      got.red = m_tdata[31:24];
      got.green = m_tdata[39:32];
      got.blue = m_tdata[47:40];
      got.alpha = m_tdata[55:48];
      got.image_width = m_tdata[68:56];
      got.image_height = m_tdata[81:69];
      got.error_code = m_tdata[84:82];
      got.last = m_tlast;
      sb.check_result(got);
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (rx_left % 3 == 0);
      default: m_tready <= (rx_left % 16 >= 12);
    endcase
  end

  initial begin
    bit [31:0]   w, h, off;
    bit [7:0]    dep;
    int          n;
    int unsigned pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ---------------- Directed files ----------------
    // Short header: the file ends on its very first byte, then on byte 52.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 2, 2, DEPTH_24, 0);
    send_bmp(1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 2, 2, DEPTH_24, 0);
    send_bmp(HDR_LAST);
    // Bad signature on either byte; the bytes after the error are ignored.
    make_bmp(NOT_SIG, SIG_M, OFFSET_MIN, 2, 2, DEPTH_24, 0);
    send_bmp(HDR_LAST + 5);
    make_bmp(SIG_B, NOT_SIG, OFFSET_MIN, 2, 2, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    // Unsupported depth, alone and together with a bad signature (signature wins).
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 2, 2, 8'd16, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(8'h00, SIG_M, OFFSET_MIN, 2, 2, 8'd16, 0);
    send_bmp(HDR_LAST + 1);
    // Dimensions: zero width, zero height, negative width, one column too many,
    // one row too many in a top-down file, and the most negative height.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 0, 3, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 3, 0, DEPTH_32, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, -3, 3, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, MAX_W + 1, 3, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 3, -(MAX_H + 1), DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 3, 32'h8000_0000, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    // Bad dimensions outrank a bad offset; then offsets just below 54 and zero.
    make_bmp(SIG_B, SIG_M, 0, 0, 3, DEPTH_24, 0);
    send_bmp(HDR_LAST + 1);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN - 1, 3, 3, DEPTH_24, 0);
    send_bmp(HDR_LAST + 3);
    make_bmp(SIG_B, SIG_M, 0, 3, 3, DEPTH_32, 0);
    send_bmp(HDR_LAST + 1);
    // Largest accepted image, top-down; the file ends on the last header byte, so the
    // header result and a truncation error come out of the same beat.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, MAX_W, -MAX_H, DEPTH_32, 0);
    send_bmp(HDR_LAST + 1);
    // Largest image bottom-up: the first stored pixel lands at the start of the last
    // top-down row, and the file ends right after that pixel.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, MAX_W, MAX_H, DEPTH_24, 0);
    send_bmp(HDR_LAST + 4);
    // End of file while skipping toward a far pixel offset.
    make_bmp(SIG_B, SIG_M, 32'h8000_0036, 2, 2, DEPTH_24, 0);
    send_bmp(HDR_LAST + 10);
    // One pixel per row, 24-bit: end of file inside a pixel, then inside the padding.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 1, 2, DEPTH_24, 1);
    send_bmp(HDR_LAST + 3);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 1, 2, DEPTH_24, 1);
    send_bmp(HDR_LAST + 5);
    // Complete files: bottom-up 24-bit ending on the final pixel byte, top-down 32-bit
    // with a skip and trailing bytes, and a single 32-bit pixel.
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 3, 2, DEPTH_24, 1);
    send_bmp(bmp_q.size() - tail_pad);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN + 6, 2, -3, DEPTH_32, 1);
    send_bmp(bmp_q.size() + 5);
    make_bmp(SIG_B, SIG_M, OFFSET_MIN, 1, 1, DEPTH_32, 1);
    send_bmp(bmp_q.size());

    // ---------------- Random files ----------------
    // Mostly well-formed small images with random pixels, some large images that are
    // only begun, corrupted headers, short headers and plain noise.
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      dep = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 1)) h = -h;
      off = OFFSET_MIN + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0);
      if (pick < 65) begin
        make_bmp(SIG_B, SIG_M, off, w, h, dep, 1);
        case ($urandom_range(0, 9))
          0, 1: n = $urandom_range(HDR_LAST + 1, bmp_q.size() - 1);
          2: n = bmp_q.size() + $urandom_range(1, 6);
          3, 4: n = bmp_q.size() - tail_pad;
          default: n = bmp_q.size();
        endcase
      end else if (pick < 72) begin
        w = ($urandom_range(0, 3) == 0) ? MAX_W : $urandom_range(1, MAX_W);
        h = ($urandom_range(0, 3) == 0) ? MAX_H : $urandom_range(1, MAX_H);
        if ($urandom_range(0, 1)) h = -h;
        make_bmp(SIG_B, SIG_M, off, w, h, dep, 0);
        n = HDR_LAST + 1 + $urandom_range(0, 40);
      end else if (pick < 87) begin
        make_bmp(SIG_B, SIG_M, off, w, h, dep, 1);
        case ($urandom_range(0, 5))
          0: bmp_q[$urandom_range(HDR_SIG0, HDR_SIG1)] = 8'($urandom);
          1: bmp_q[HDR_DEPTH] = 8'($urandom);
          2: for (int i = 0; i < 4; i++) bmp_q[HDR_WID_LO + i] = 8'($urandom);
          3: for (int i = 0; i < 4; i++) bmp_q[HDR_HGT_LO + i] = 8'($urandom);
          4: begin
            bmp_q[HDR_OFF_LO] = 8'($urandom_range(0, OFFSET_MIN - 1));
            for (int i = 1; i < 4; i++) bmp_q[HDR_OFF_LO + i] = 8'h00;
          end
          default: begin
            w = MAX_W + $urandom_range(1, 100);
            for (int i = 0; i < 4; i++) bmp_q[HDR_WID_LO + i] = w[8*i +: 8];
          end
        endcase
        n = HDR_LAST + 1 + $urandom_range(0, 12);
      end else if (pick < 95) begin
        make_bmp(SIG_B, SIG_M, off, w, h, dep, 0);
        n = $urandom_range(1, HDR_LAST);
      end else begin
        bmp_q.delete();
        n = $urandom_range(1, 80);
      end
      send_bmp(n);
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every predicted result, then keep the clock running so that a
    // stray extra result would still be caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmpdec_pkg.sv
hdl/bmpdec_parser.sv
hdl/bmpdec_out_queue.sv
hdl/bmp_stream_to_rgba_decoder_top.sv
tb/bmp_stream_to_rgba_decoder_top_tb.sv
